/* hdl/itoa_pkg.sv */
// Types, constants and helper functions shared by the integer-to-text converter.
// Used by itoa_div.sv and integer_to_ascii_radix_top.sv; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

   localparam int RADIX_BITS = 6;
   localparam int REM_BITS   = 6;
   localparam int CHAR_BITS  = 8;
   localparam int LEN_BITS   = 6;

   localparam logic [RADIX_BITS-1:0] RADIX_MIN     = 6'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX     = 6'd36;
   localparam logic [RADIX_BITS-1:0] RADIX_DECIMAL = 6'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_RESET   = 6'd10;

   localparam logic [REM_BITS-1:0]  DIGIT_TEN  = 6'd10;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_A     = 8'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2d;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   function automatic logic [RADIX_BITS-1:0] radix_clamp(input logic [RADIX_BITS-1:0] r);
      logic [RADIX_BITS-1:0] res;
      res = r;
      if (r < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         res = RADIX_MAX;
      end
      return res;
   endfunction

   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [REM_BITS-1:0] d);
      logic [CHAR_BITS-1:0] res;
      if (d < DIGIT_TEN) begin
         res = CHAR_ZERO + CHAR_BITS'(d);
      end else begin
         res = CHAR_A + CHAR_BITS'(d - DIGIT_TEN);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

/* hdl/itoa_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle by a small radix.
// Depends on itoa_pkg for the divisor and remainder widths.
`timescale 1ns / 1ps
`default_nettype none

module itoa_div #(
   parameter int WORD_BITS = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [WORD_BITS-1:0]             dividend,
   input  wire logic [itoa_pkg::RADIX_BITS-1:0]  divisor,
   output logic                                  done,
   output logic [WORD_BITS-1:0]                  quotient,
   output logic [itoa_pkg::REM_BITS-1:0]         remainder
);

   localparam int CNT_BITS = $clog2(WORD_BITS);

   logic [WORD_BITS-1:0]              quot_ff;
   logic [itoa_pkg::REM_BITS-1:0]     rem_ff;
   logic [itoa_pkg::RADIX_BITS-1:0]   div_ff;
   logic [CNT_BITS-1:0]               cnt_ff;
   logic                              busy_ff;
   logic                              done_ff;

   logic [itoa_pkg::REM_BITS:0]       trial;
   logic [itoa_pkg::REM_BITS:0]       diff;
   logic                              fits;

   assign trial = {rem_ff, quot_ff[WORD_BITS-1]};
   assign fits  = trial >= {1'b0, div_ff};
   assign diff  = trial - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff) begin
         busy_ff <= (cnt_ff != '0);
         done_ff <= (cnt_ff == '0);
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= dividend;
         rem_ff  <= '0;
         div_ff  <= divisor;
         cnt_ff  <= CNT_BITS'(WORD_BITS - 1);
      end else if (busy_ff) begin
         quot_ff <= {quot_ff[WORD_BITS-2:0], fits};
         rem_ff  <= fits ? diff[itoa_pkg::REM_BITS-1:0] : trial[itoa_pkg::REM_BITS-1:0];
         cnt_ff  <= cnt_ff - 1'b1;
      end
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a division in flight");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < div_ff))
      else $error("remainder not below divisor");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider busy and done together");

endmodule

`default_nettype wire

/* hdl/integer_to_ascii_radix_top.sv */
// Integer to ASCII text in a configurable radix, most significant character first.
// Steps: the value is taken in idle, each digit is then found by the bit-serial
// divider, one quotient bit per cycle, and each character goes into the output register,
// which back-pressure on the result stream can hold. One value at a time: a new one
// is taken only after the last character of the previous one is loaded for output.
// Reset: radix returns to 10, control clears; the digit stack is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_radix_top #(
   parameter int WORD_BITS  = 32,
   parameter int MAX_DIGITS = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wen,
   input  wire logic [itoa_pkg::RADIX_BITS-1:0]   csr_wdata,    // radix
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [((WORD_BITS+7)/8)*8-1:0]    req_tdata,    // value
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [itoa_pkg::CHAR_BITS-1:0]         rsp_tdata,    // character
   output logic                                   rsp_tlast,
   output logic [itoa_pkg::LEN_BITS-1:0]          rsp_tuser     // length
);

   localparam int CW = $clog2(MAX_DIGITS + 1);

   itoa_pkg::state_type                st_ff, st_in;
   logic [itoa_pkg::RADIX_BITS-1:0]    radix_ff;
   logic                               neg_ff, neg_in;
   logic                               dash_ff, dash_in;
   logic [CW-1:0]                      count_ff, count_in;
   logic [itoa_pkg::LEN_BITS-1:0]      total_ff, total_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [itoa_pkg::CHAR_BITS-1:0]     rsp_char_ff, rsp_char_in;
   logic                               rsp_last_ff, rsp_last_in;
   logic [itoa_pkg::LEN_BITS-1:0]      rsp_len_ff, rsp_len_in;
   logic [itoa_pkg::REM_BITS-1:0]      stack_ff [MAX_DIGITS];

   logic                               accept;
   logic [WORD_BITS-1:0]               value;
   logic [itoa_pkg::RADIX_BITS-1:0]    radix_eff;
   logic                               neg_now;
   logic [WORD_BITS-1:0]               magnitude;
   logic [CW-1:0]                      count_next;
   logic [CW-1:0]                      cap;
   logic                               more;
   logic                               out_load;
   logic                               emit_last;
   logic                               push;
   logic                               pop;

   logic                               div_start;
   logic [WORD_BITS-1:0]               div_dividend;
   logic                               div_done;
   logic [WORD_BITS-1:0]               div_quot;
   logic [itoa_pkg::REM_BITS-1:0]      div_rem;

   itoa_div #(
      .WORD_BITS (WORD_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (radix_eff),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   assign req_tready = (st_ff == itoa_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign value      = req_tdata[WORD_BITS-1:0];
   assign radix_eff  = itoa_pkg::radix_clamp(radix_ff);
   assign neg_now    = value[WORD_BITS-1] && (radix_eff == itoa_pkg::RADIX_DECIMAL);
   assign magnitude  = neg_now ? (WORD_BITS'(0) - value) : value;
   assign count_next = count_ff + 1'b1;
   assign cap        = CW'(MAX_DIGITS) - CW'(neg_ff);
   assign more       = (div_quot != '0) && (count_next < cap);
   assign out_load   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      st_in        = st_ff;
      neg_in       = neg_ff;
      dash_in      = dash_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_len_in   = rsp_len_ff;
      div_start    = 1'b0;
      div_dividend = div_quot;
      push         = 1'b0;
      pop          = 1'b0;
      emit_last    = 1'b0;
      unique case (st_ff)
         itoa_pkg::ST_IDLE: begin
            if (accept) begin
               neg_in       = neg_now;
               dash_in      = neg_now;
               count_in     = '0;
               div_start    = 1'b1;
               div_dividend = magnitude;
               st_in        = itoa_pkg::ST_DIV;
            end
         end
         itoa_pkg::ST_DIV: begin
            if (div_done) begin
               push     = 1'b1;
               count_in = count_next;
               if (more) begin
                  div_start = 1'b1;
               end else begin
                  total_in = itoa_pkg::LEN_BITS'(count_next + CW'(neg_ff));
                  st_in    = itoa_pkg::ST_EMIT;
               end
            end
         end
         itoa_pkg::ST_EMIT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               if (dash_ff) begin
                  rsp_char_in = itoa_pkg::CHAR_MINUS;
                  dash_in     = 1'b0;
                  emit_last   = (count_ff == '0);
               end else begin
                  pop         = 1'b1;
                  rsp_char_in = itoa_pkg::digit_char(stack_ff[0]);
                  count_in    = count_ff - 1'b1;
                  emit_last   = (count_ff == CW'(1));
               end
               rsp_last_in = emit_last;
               rsp_len_in  = emit_last ? total_ff : '0;
               if (emit_last) begin
                  st_in = itoa_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            st_in = itoa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= itoa_pkg::ST_IDLE;
         radix_ff     <= itoa_pkg::RADIX_RESET;
         neg_ff       <= 1'b0;
         dash_ff      <= 1'b0;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         neg_ff       <= neg_in;
         dash_ff      <= dash_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            radix_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_len_ff  <= rsp_len_in;
   end

   // push shifts toward the bottom, pop brings the next digit to the top
   always_ff @(posedge clock) begin
      if (push) begin
         stack_ff[0] <= div_rem;
         for (int i = 1; i < MAX_DIGITS; i++) begin
            stack_ff[i] <= stack_ff[i-1];
         end
      end else if (pop) begin
         for (int i = 0; i < MAX_DIGITS - 1; i++) begin
            stack_ff[i] <= stack_ff[i+1];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_len_ff;

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (st_ff == itoa_pkg::ST_IDLE) |-> (count_ff == '0) && !dash_ff)
      else $error("digits left over when idle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_DIGITS))
      else $error("digit count beyond stack depth");

   a_len_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (rsp_tuser == '0))
      else $error("length on a character that is not the last");

   a_div_in_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (st_ff == itoa_pkg::ST_DIV))
      else $error("division finished outside the divide state");

endmodule

`default_nettype wire

/* tb/sv/tb_integer_to_ascii_radix_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for integer_to_ascii_radix_top: directed and random values over many
// radix settings, every streamed character compared with a behavioral text formatter.
// Depends on itoa_pkg and integer_to_ascii_radix_top.
module tb_integer_to_ascii_radix_top;

   typedef struct packed {
      logic [itoa_pkg::CHAR_BITS-1:0] code;
      logic                           tail;
      logic [itoa_pkg::LEN_BITS-1:0]  count;
   } text_char_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            csr_wen    = 1'b0;
   logic [itoa_pkg::RADIX_BITS-1:0] csr_wdata  = '0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [31:0]                     req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [itoa_pkg::CHAR_BITS-1:0]  rsp_tdata;
   logic                            rsp_tlast;
   logic [itoa_pkg::LEN_BITS-1:0]   rsp_tuser;

   text_char_type                   pending_chars[$];
   logic [itoa_pkg::RADIX_BITS-1:0] radix_setting = itoa_pkg::RADIX_RESET;
   int                              error_count   = 0;
   int                              req_gap_pct   = 0;
   int                              rsp_stall_pct = 0;
   int                              rsp_hold      = 0;

   always #10 clock = ~clock;

   integer_to_ascii_radix_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Format one value in the current radix and queue its characters.
   function automatic void queue_text_of(input logic [31:0] value);
      logic [itoa_pkg::RADIX_BITS-1:0] base;
      logic [itoa_pkg::RADIX_BITS-1:0] digit;
      logic [31:0]                     mag;
      logic [itoa_pkg::CHAR_BITS-1:0]  chars [32];
      int                              ndig;
      int                              total;
      int                              i;
      bit                              neg;
      text_char_type                   rec;
      base = radix_setting;
      if (base < itoa_pkg::RADIX_MIN) begin
         base = itoa_pkg::RADIX_MIN;
      end else if (base > itoa_pkg::RADIX_MAX) begin
         base = itoa_pkg::RADIX_MAX;
      end
      neg  = value[31] && (base == itoa_pkg::RADIX_DECIMAL);
      mag  = neg ? -value : value;
      ndig = 0;
      do begin
         digit = itoa_pkg::RADIX_BITS'(mag % {26'd0, base});
         if (digit < itoa_pkg::DIGIT_TEN) begin
            chars[ndig] = itoa_pkg::CHAR_ZERO + itoa_pkg::CHAR_BITS'(digit);
         end else begin
            chars[ndig] = itoa_pkg::CHAR_A
                        + itoa_pkg::CHAR_BITS'(digit - itoa_pkg::DIGIT_TEN);
         end
         ndig++;
         mag = mag / {26'd0, base};
      end while (mag != 0 && ndig < 32 - int'(neg));
      total = ndig + int'(neg);
      if (neg) begin
         rec.code  = itoa_pkg::CHAR_MINUS;
         rec.tail  = 1'b0;
         rec.count = '0;
         pending_chars.push_back(rec);
      end
      for (i = ndig - 1; i >= 0; i--) begin
         rec.code  = chars[i];
         rec.tail  = (i == 0);
         rec.count = (i == 0) ? itoa_pkg::LEN_BITS'(total) : '0;
         pending_chars.push_back(rec);
      end
   endfunction

   // Check each character transfer and stall the result side in random bursts.
   always @(posedge clock) begin
      text_char_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected character 0x%02h", rsp_tdata));
            end else begin
               want = pending_chars.pop_front();
               if (rsp_tdata !== want.code) begin
                  report_mismatch($sformatf("character 0x%02h, want 0x%02h",
                                            rsp_tdata, want.code));
               end
               if (rsp_tlast !== want.tail) begin
                  report_mismatch($sformatf("last %b, want %b", rsp_tlast, want.tail));
               end
               if (rsp_tuser !== want.count) begin
                  report_mismatch($sformatf("length %0d, want %0d", rsp_tuser, want.count));
               end
            end
         end
         if (!rsp_tready) begin
            if (rsp_hold != 0) begin
               rsp_hold--;
            end else begin
               rsp_tready <= 1'b1;
            end
         end else if (rsp_stall_pct != 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_tready <= 1'b0;
            rsp_hold = $urandom_range(0, 3);
         end
      end
   end

   task automatic send_value(input logic [31:0] value);
      int gap;
      if (req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      queue_text_of(value);
   endtask

   // Drop valid and hold until every queued character has been transferred.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_chars.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_radix(input logic [itoa_pkg::RADIX_BITS-1:0] value);
      wait_idle();
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      radix_setting = value;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 6))
         0:       return $urandom_range(0, 40);
         1:       return -$urandom_range(1, 40);
         2:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
         3:       return 32'h8000_0000 + $urandom_range(0, 3);
         4:       return 32'h1 << $urandom_range(0, 31);
         default: return $urandom();
      endcase
   endfunction

   task automatic test_default_radix();
      req_gap_pct   = 30;
      rsp_stall_pct = 20;
      send_value(32'd0);
      send_value(32'd1);
      send_value(32'd9);
      send_value(32'd10);
      send_value(32'hFFFF_FFFF);
      send_value(-32'd10);
      send_value(32'h7FFF_FFFF);
      send_value(32'h8000_0000);
      send_value(32'd123456789);
   endtask

   task automatic test_binary_radix();
      write_radix(itoa_pkg::RADIX_MIN);
      send_value(32'd0);
      send_value(32'hFFFF_FFFF);
      send_value(32'h8000_0000);
      send_value(32'h7FFF_FFFF);
      send_value(32'd1);
   endtask

   task automatic test_base36_radix();
      write_radix(itoa_pkg::RADIX_MAX);
      send_value(32'd35);
      send_value(32'd36);
      send_value(32'hFFFF_FFFF);
      send_value(-32'd36);
   endtask

   task automatic test_radix_clamp();
      write_radix(6'd0);
      send_value(32'hFFFF_FFFF);
      write_radix(6'd1);
      send_value(32'd5);
      write_radix(6'd37);
      send_value(32'd1296);
      write_radix(6'd63);
      send_value(32'h8000_0000);
   endtask

   task automatic test_random_phases();
      int phase;
      int n;
      for (phase = 0; phase < 8; phase++) begin
         if (phase == 0) begin
            write_radix(itoa_pkg::RADIX_DECIMAL);
         end else if (phase % 4 == 3) begin
            write_radix(itoa_pkg::RADIX_BITS'($urandom_range(0, 63)));
         end else begin
            write_radix(itoa_pkg::RADIX_BITS'($urandom_range(2, 36)));
         end
         req_gap_pct   = (phase == 2) ? 0 : $urandom_range(10, 50);
         rsp_stall_pct = (phase == 2) ? 0 : $urandom_range(10, 50);
         for (n = 0; n < 50; n++) begin
            if (phase == 4 && n == 25) begin
               wait_idle();
            end
            send_value(pick_value());
         end
      end
   endtask

   task automatic test_quiet_tail();
      int n;
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      write_radix(itoa_pkg::RADIX_DECIMAL);
      for (n = 0; n < 40; n++) begin
         send_value(pick_value());
      end
      write_radix(6'd16);
      for (n = 0; n < 40; n++) begin
         send_value(pick_value());
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_default_radix();
      test_binary_radix();
      test_base36_radix();
      test_radix_clamp();
      test_random_phases();
      test_quiet_tail();
      wait_idle();
      repeat (40) @(posedge clock);
      if (pending_chars.size() != 0) begin
         report_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));
      end
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #100_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

/* files.f */
hdl/itoa_pkg.sv
hdl/itoa_div.sv
hdl/integer_to_ascii_radix_top.sv
tb/sv/tb_integer_to_ascii_radix_top.sv
